/* hw/rtl/assert_macros.svh */
// Assertion helpers; both expect clk in the enclosing module, and FCPG_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define FCPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define FCPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCPG_ASSERT(lbl, prop, msg)
`define FCPG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/fcpg_pkg.sv */
package fcpg_pkg;

  localparam int CORDIC_STAGES_DEF   = 20;
  localparam int PHASE_FRAC_BITS_DEF = 24;

  localparam int TIME_W   = 40;
  localparam int MAG_W    = 24;
  localparam int INIT_W   = 16;
  localparam int FREQ_W   = 32;
  localparam int SIG_W    = 25;
  localparam int IFREQ_W  = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PHASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_FREQ      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_AMP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZIGZAG        = 3'd5;

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [28:0] INV_PI_SQ_Q32  = 29'd435171170;

  localparam logic [31:0] ATAN_TURNS [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85005780, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
    if (v > 33'sd1073741824) begin
      return ONE_Q30;
    end else if (v < -33'sd1073741824) begin
      return -ONE_Q30;
    end
    return v[31:0];
  endfunction

endpackage

/* hw/rtl/fcpg_cordic.sv */
`include "assert_macros.svh"

module fcpg_cordic import fcpg_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ctl_t                ctl,
  input  logic [31:0]              angle,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_vld,
  output logic signed [31:0]       cos_o,
  output logic signed [31:0]       sin_o,
  output logic [SIDE_W-1:0]        side_out
);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  logic signed [32:0] x_r [STAGES];
  logic signed [32:0] y_r [STAGES];
  logic signed [32:0] z_r [STAGES];
  logic [1:0]         quad_r [STAGES];
  logic [SIDE_W-1:0]  side_r [STAGES];
  logic               vld_r [STAGES];

  genvar i;
  for (i = 0; i < STAGES; i++) begin : g_stage
    logic signed [32:0] x_in, y_in, z_in, dx, dy;
    logic [1:0]         q_in;
    logic [SIDE_W-1:0]  s_in;
    logic               v_in;
    if (i == 0) begin : g_first
      assign x_in = CORDIC_X0;
      assign y_in = '0;
      assign z_in = {3'b000, angle[29:0]};
      assign q_in = angle[31:30];
      assign s_in = side_in;
      assign v_in = ctl.vld;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign q_in = quad_r[i-1];
      assign s_in = side_r[i-1];
      assign v_in = vld_r[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if (!z_in[32]) begin
          x_r[i] <= x_in - dx;
          y_r[i] <= y_in + dy;
          z_r[i] <= z_in - $signed({1'b0, ATAN_TURNS[i]});
        end else begin
          x_r[i] <= x_in + dx;
          y_r[i] <= y_in - dy;
          z_r[i] <= z_in + $signed({1'b0, ATAN_TURNS[i]});
        end
        quad_r[i] <= q_in;
        side_r[i] <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[i] <= v_in;
      end
    end
  end

  logic signed [31:0] xc, yc, cos_nxt, sin_nxt, cos_r, sin_r;
  logic [SIDE_W-1:0]  side_o_r;
  logic               vld_o_r;

  assign xc = clamp_q30(x_r[STAGES-1]);
  assign yc = clamp_q30(y_r[STAGES-1]);

  // Fold the quadrant back in after the rotation.
  always_comb begin
    case (quad_r[STAGES-1])
      QUAD_I: begin
        cos_nxt = xc;
        sin_nxt = yc;
      end
      QUAD_II: begin
        cos_nxt = -yc;
        sin_nxt = xc;
      end
      QUAD_III: begin
        cos_nxt = -xc;
        sin_nxt = -yc;
      end
      default: begin
        cos_nxt = yc;
        sin_nxt = -xc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      cos_r    <= cos_nxt;
      sin_r    <= sin_nxt;
      side_o_r <= side_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (ctl.en) begin
      vld_o_r <= vld_r[STAGES-1];
    end
  end

  assign out_vld  = vld_o_r;
  assign cos_o    = cos_r;
  assign sin_o    = sin_r;
  assign side_out = side_o_r;

  `FCPG_ASSERT(a_cos_range, vld_o_r |-> (cos_r <= ONE_Q30 && cos_r >= -ONE_Q30), "cos out of range")
  `FCPG_ASSERT(a_sin_range, vld_o_r |-> (sin_r <= ONE_Q30 && sin_r >= -ONE_Q30), "sin out of range")
  `FCPG_ASSERT(a_hold, !ctl.en |=> $stable(vld_o_r), "cordic moved while held")

endmodule

/* hw/rtl/fcpg_divider.sv */
module fcpg_divider import fcpg_pkg::*; #(
  parameter int NUM_W  = 62,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_ctl_t         ctl,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  // One quotient bit per stage; work holds remaining dividend bits and quotient bits.
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  work_r [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];
  logic              vld_r  [NUM_W];

  genvar i;
  for (i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  work_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in, ge;
    logic [DEN_W:0]    trial, diff;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = num;
      assign s_in    = side_in;
      assign v_in    = ctl.vld;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign work_in = work_r[i-1];
      assign s_in    = side_r[i-1];
      assign v_in    = vld_r[i-1];
    end
    assign trial = {rem_in, work_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        work_r[i] <= {work_in[NUM_W-2:0], ge};
        side_r[i] <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[i] <= v_in;
      end
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign quot     = work_r[NUM_W-1];
  assign side_out = side_r[NUM_W-1];

endmodule

/* hw/rtl/fm_cosine_phasor_generator_top.sv */
// FM phasor source: each request carries an absolute sample time (2^-24 s) and
// returns magnitude*(cos, sin) of the modulated phase plus the instantaneous
// frequency (2^-16 Hz). One request is taken per clock while in_stall is low,
// and results leave in request order through the two CORDIC pipelines and the
// 62-stage quotient pipeline of the sinusoidal phase term. A two-entry output
// buffer keeps taking requests after out_stall rises until a stalled result
// fills its skid entry. Write the registers only with nothing in flight.
`include "assert_macros.svh"

module fm_cosine_phasor_generator_top import fcpg_pkg::*; #(
  parameter int CORDIC_STAGES       = CORDIC_STAGES_DEF,
  parameter int PHASE_FRACTION_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TIME_W-1:0]         in_sample_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SIG_W-1:0]   out_signal_real,
  output logic signed [SIG_W-1:0]   out_signal_imag,
  output logic signed [IFREQ_W-1:0] out_instant_frequency,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int P    = PHASE_FRACTION_BITS;
  localparam int SC_W = 2 * P + 33;
  localparam int SD_W = 2 * P + 35;

  // Registers
  logic [MAG_W-1:0]  mag_r;
  logic [INIT_W-1:0] init_ph_r;
  logic [FREQ_W-1:0] base_r, fm_r, amp_r;
  logic              zig_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r     <= '0;
      init_ph_r <= '0;
      base_r    <= '0;
      fm_r      <= '0;
      amp_r     <= '0;
      zig_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAGNITUDE:     mag_r     <= cfg_data[MAG_W-1:0];
        CFG_INITIAL_PHASE: init_ph_r <= cfg_data[INIT_W-1:0];
        CFG_BASE_FREQ:     base_r    <= cfg_data;
        CFG_MOD_FREQ:      fm_r      <= cfg_data;
        CFG_MOD_AMP:       amp_r     <= cfg_data;
        CFG_ZIGZAG:        zig_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en, skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // S1: partial products of time, kept modulo 2^40
  logic        v1_r;
  logic [63:0] bt_lo_r, wm_lo_r;
  logic [15:0] bt_hi_r, wm_hi_r;
  always_ff @(posedge clk) begin
    if (en) begin
      bt_lo_r <= base_r * in_sample_time[31:0];
      bt_hi_r <= base_r[7:0] * in_sample_time[39:32];
      wm_lo_r <= fm_r * in_sample_time[31:0];
      wm_hi_r <= fm_r[7:0] * in_sample_time[39:32];
    end
  end

  // S2: base phase and modulation product
  logic         v2_r;
  logic [39:0]  bt40, wm40, wm2_r;
  logic [P-1:0] init_sh, ph2_r;
  assign bt40    = bt_lo_r[39:0] + {bt_hi_r[7:0], 32'd0};
  assign wm40    = wm_lo_r[39:0] + {wm_hi_r[7:0], 32'd0};
  assign init_sh = P'(init_ph_r) << (P - 16);
  always_ff @(posedge clk) begin
    if (en) begin
      ph2_r <= bt40[39:40-P] + init_sh;
      wm2_r <= wm40;
    end
  end

  // S3: triangle distance |2f-1|
  logic         v3_r, odd3_r, dneg3_r;
  logic [31:0]  f32, ad_nxt, ad3_r, ang3_r;
  logic [P-1:0] ph3_r;
  assign f32    = wm2_r[38:7];
  assign ad_nxt = f32[31] ? {1'b0, f32[30:0]} : 32'h8000_0000 - f32;
  always_ff @(posedge clk) begin
    if (en) begin
      ph3_r   <= ph2_r;
      ang3_r  <= wm2_r[39:8];
      ad3_r   <= ad_nxt;
      odd3_r  <= wm2_r[39];
      dneg3_r <= !f32[31];
    end
  end

  // S4
  logic         v4_r, odd4_r, dneg4_r;
  logic [62:0]  sq4_r;
  logic [63:0]  adamp4_r;
  logic [31:0]  ang4_r;
  logic [P-1:0] ph4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sq4_r    <= ad3_r * ad3_r;
      adamp4_r <= amp_r * ad3_r;
      ph4_r    <= ph3_r;
      ang4_r   <= ang3_r;
      odd4_r   <= odd3_r;
      dneg4_r  <= dneg3_r;
    end
  end

  // S5: e = 1 - d*d, zigzag deviation
  logic         v5_r, odd5_r, zneg5_r;
  logic [62:0]  e_diff;
  logic [63:0]  zdev_sum;
  logic [31:0]  e5_r, zdev5_r, ang5_r;
  logic [P-1:0] ph5_r;
  assign e_diff   = (63'd1 << 62) - sq4_r;
  assign zdev_sum = adamp4_r + (64'd1 << 30);
  always_ff @(posedge clk) begin
    if (en) begin
      e5_r    <= e_diff[62:31];
      zdev5_r <= zdev_sum[62:31];
      zneg5_r <= dneg4_r != !odd4_r;
      odd5_r  <= odd4_r;
      ph5_r   <= ph4_r;
      ang5_r  <= ang4_r;
    end
  end

  // S6
  logic         v6_r, odd6_r, zneg6_r;
  logic [63:0]  p6_r;
  logic [31:0]  zdev6_r, ang6_r;
  logic [P-1:0] ph6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p6_r    <= amp_r * e5_r;
      zdev6_r <= zdev5_r;
      zneg6_r <= zneg5_r;
      odd6_r  <= odd5_r;
      ph6_r   <= ph5_r;
      ang6_r  <= ang5_r;
    end
  end

  // S7: split the 1/pi^2 product
  logic         v7_r, odd7_r, zneg7_r;
  logic [60:0]  plo7_r, phi7_r;
  logic [31:0]  zdev7_r, ang7_r;
  logic [P-1:0] ph7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      plo7_r  <= p6_r[31:0] * INV_PI_SQ_Q32;
      phi7_r  <= p6_r[63:32] * INV_PI_SQ_Q32;
      zdev7_r <= zdev6_r;
      zneg7_r <= zneg6_r;
      odd7_r  <= odd6_r;
      ph7_r   <= ph6_r;
      ang7_r  <= ang6_r;
    end
  end

  // S8: zigzag phase term, fraction of a turn
  logic         v8_r, zneg8_r;
  logic [78:0]  sum79;
  logic [P-1:0] zt, ph8_r, zterm8_r;
  logic [31:0]  zdev8_r, ang8_r;
  assign sum79 = 79'(plo7_r) + (79'(phi7_r) << 32);
  assign zt    = sum79[78:79-P];
  always_ff @(posedge clk) begin
    if (en) begin
      zterm8_r <= odd7_r ? P'(0) - zt : zt;
      zdev8_r  <= zdev7_r;
      zneg8_r  <= zneg7_r;
      ph8_r    <= ph7_r;
      ang8_r   <= ang7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // Modulating waveform
  pipe_ctl_t          ctl1;
  logic               v9c;
  logic signed [31:0] mc, ms;
  logic [SC_W-1:0]    side9c;
  assign ctl1 = '{en: en, vld: v8_r};

  fcpg_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SC_W)) u_cordic_mod (
    .clk(clk), .rst_n(rst_n), .ctl(ctl1), .angle(ang8_r),
    .side_in({ph8_r, zterm8_r, zneg8_r, zdev8_r}),
    .out_vld(v9c), .cos_o(mc), .sin_o(ms), .side_out(side9c)
  );

  // S9: amplitude products
  logic            v9_r, mcneg9_r, msneg9_r;
  logic [31:0]     mcabs, msabs;
  logic [62:0]     sprod9_r;
  logic [61:0]     nprod9_r;
  logic [SC_W-1:0] side9_r;
  assign mcabs = mc[31] ? 32'(-mc) : 32'(mc);
  assign msabs = ms[31] ? 32'(-ms) : 32'(ms);
  always_ff @(posedge clk) begin
    if (en) begin
      sprod9_r <= amp_r * mcabs[30:0];
      nprod9_r <= amp_r * msabs[30:0];
      mcneg9_r <= mc[31];
      msneg9_r <= ms[31];
      side9_r  <= side9c;
    end
  end

  // S10: instantaneous frequency
  logic                      v10_r, msneg10_r;
  logic [62:0]               sdev_sum;
  logic [31:0]               devmag;
  logic                      devneg;
  logic signed [IFREQ_W-1:0] dev, freq_nxt, freq10_r;
  logic [61:0]               n10_r;
  logic [P-1:0]              ph10_r, zterm10_r;
  assign sdev_sum = sprod9_r + (63'd1 << 29);
  assign devmag   = zig_r ? side9_r[31:0] : sdev_sum[61:30];
  assign devneg   = zig_r ? side9_r[32] : mcneg9_r;
  assign dev      = devneg ? -$signed(IFREQ_W'(devmag)) : $signed(IFREQ_W'(devmag));
  assign freq_nxt = $signed(IFREQ_W'(base_r)) + dev;
  always_ff @(posedge clk) begin
    if (en) begin
      freq10_r  <= freq_nxt;
      n10_r     <= nprod9_r;
      msneg10_r <= msneg9_r;
      ph10_r    <= side9_r[SC_W-1:P+33];
      zterm10_r <= side9_r[P+32:33];
    end
  end

  // A*|sin| / fm
  pipe_ctl_t       ctl2;
  logic            v11d;
  logic [61:0]     quot;
  logic [SD_W-1:0] side11d;
  assign ctl2 = '{en: en, vld: v10_r};

  fcpg_divider #(.NUM_W(62), .DEN_W(FREQ_W), .SIDE_W(SD_W)) u_divider (
    .clk(clk), .rst_n(rst_n), .ctl(ctl2), .num(n10_r), .den(fm_r),
    .side_in({ph10_r, zterm10_r, msneg10_r, freq10_r}),
    .out_vld(v11d), .quot(quot), .side_out(side11d)
  );

  // S11: quotient times 1/(2 pi), modulo 2^62
  logic            v11_r;
  logic [60:0]     qh_prod, qlk11_r;
  logic [30:0]     qhk11_r;
  logic [SD_W-1:0] side11_r;
  assign qh_prod = quot[61:31] * INV_TWO_PI_Q32;
  always_ff @(posedge clk) begin
    if (en) begin
      qlk11_r  <= quot[30:0] * INV_TWO_PI_Q32;
      qhk11_r  <= qh_prod[30:0];
      side11_r <= side11d;
    end
  end

  // S12: full phase and CORDIC angle
  logic                      v12_r;
  logic [61:0]               s62;
  logic [P-1:0]              st, sterm, term, phase;
  logic [P+31:0]             ang_wide;
  logic [31:0]               ang12_r;
  logic signed [IFREQ_W-1:0] freq12_r;
  assign s62   = 62'(qlk11_r) + {qhk11_r, 31'd0};
  assign st    = s62[61:62-P];
  assign sterm = (fm_r == '0) ? '0 : (side11_r[IFREQ_W] ? P'(0) - st : st);
  assign term  = zig_r ? side11_r[P+IFREQ_W:IFREQ_W+1] : sterm;
  assign phase = side11_r[SD_W-1:P+IFREQ_W+1] + term;
  assign ang_wide = {phase, 32'd0} >> P;
  always_ff @(posedge clk) begin
    if (en) begin
      ang12_r  <= ang_wide[31:0];
      freq12_r <= side11_r[IFREQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else if (en) begin
      v9_r  <= v9c;
      v10_r <= v9_r;
      v11_r <= v11d;
      v12_r <= v11_r;
    end
  end

  // Carrier
  pipe_ctl_t          ctl3;
  logic               v13c;
  logic signed [31:0] cc, ss;
  logic [IFREQ_W-1:0] freq13c;
  assign ctl3 = '{en: en, vld: v12_r};

  fcpg_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(IFREQ_W)) u_cordic_car (
    .clk(clk), .rst_n(rst_n), .ctl(ctl3), .angle(ang12_r), .side_in(freq12_r),
    .out_vld(v13c), .cos_o(cc), .sin_o(ss), .side_out(freq13c)
  );

  // S13: magnitude products
  logic               v13_r, cneg13_r, sneg13_r;
  logic [31:0]        cabs, sabs;
  logic [54:0]        cprod13_r, sprod13_r;
  logic [IFREQ_W-1:0] freq13_r;
  assign cabs = cc[31] ? 32'(-cc) : 32'(cc);
  assign sabs = ss[31] ? 32'(-ss) : 32'(ss);
  always_ff @(posedge clk) begin
    if (en) begin
      cprod13_r <= mag_r * cabs[30:0];
      sprod13_r <= mag_r * sabs[30:0];
      cneg13_r  <= cc[31];
      sneg13_r  <= ss[31];
      freq13_r  <= freq13c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r <= 1'b0;
    end else if (en) begin
      v13_r <= v13c;
    end
  end

  logic [54:0]             rc_sum, rs_sum;
  logic signed [SIG_W-1:0] re_nxt, im_nxt;
  assign rc_sum = cprod13_r + (55'd1 << 29);
  assign rs_sum = sprod13_r + (55'd1 << 29);
  assign re_nxt = cneg13_r ? -$signed(rc_sum[54:30]) : $signed(rc_sum[54:30]);
  assign im_nxt = sneg13_r ? -$signed(rs_sum[54:30]) : $signed(rs_sum[54:30]);

  // Output register and skid entry
  logic                      out_valid_r;
  logic signed [SIG_W-1:0]   re_r, im_r, sk_re_r, sk_im_r;
  logic signed [IFREQ_W-1:0] fq_r, sk_fq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (!out_stall) begin
        skid_v_r <= 1'b0;
      end
    end else if (v13_r) begin
      if (out_valid_r && out_stall) begin
        skid_v_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (!out_stall) begin
        re_r <= sk_re_r;
        im_r <= sk_im_r;
        fq_r <= sk_fq_r;
      end
    end else if (v13_r) begin
      if (out_valid_r && out_stall) begin
        sk_re_r <= re_nxt;
        sk_im_r <= im_nxt;
        sk_fq_r <= freq13_r;
      end else begin
        re_r <= re_nxt;
        im_r <= im_nxt;
        fq_r <= freq13_r;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_signal_real       = re_r;
  assign out_signal_imag       = im_r;
  assign out_instant_frequency = fq_r;

  `FCPG_ASSERT(a_skid_needs_out, skid_v_r |-> out_valid_r, "skid full with output empty")
  `FCPG_ASSERT(a_skid_fill, out_valid_r && out_stall && !skid_v_r && v13_r |=> skid_v_r,
    "stalled result not parked in skid")
  `FCPG_ASSERT(a_skid_drain, skid_v_r && !out_stall |=> !skid_v_r, "skid did not drain")
  `FCPG_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid_r && !skid_v_r,
    "output not cleared by reset")

endmodule

/* test/fm_cosine_phasor_generator_top_test.sv */
`timescale 1ns / 1ps

module fm_cosine_phasor_generator_top_test;
  import fcpg_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = 2 * STAGES + 78;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX = 3'd7;

  typedef struct packed {
    logic signed [SIG_W-1:0] re;
    logic signed [SIG_W-1:0] im;
    logic signed [IFREQ_W-1:0] freq;
  } phasor_t;

  class phasor_scoreboard;
    logic [MAG_W-1:0] mag;
    logic [INIT_W-1:0] init_ph;
    logic [FREQ_W-1:0] base_f;
    logic [FREQ_W-1:0] mod_f;
    logic [FREQ_W-1:0] mod_a;
    logic zigzag;
    phasor_t pending_q[$];
    int errors;
    int checked;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAGNITUDE: mag = data[MAG_W-1:0];
        CFG_INITIAL_PHASE: init_ph = data[INIT_W-1:0];
        CFG_BASE_FREQ: base_f = data;
        CFG_MOD_FREQ: mod_f = data;
        CFG_MOD_AMP: mod_a = data;
        CFG_ZIGZAG: zigzag = data[0];
        default: ;
      endcase
    endfunction

    function void rotate(input logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = CORDIC_X0;
      y = 0;
      z = longint'(ang[29:0]);
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
        end
      end
      if (x > ONE_Q30) x = ONE_Q30;
      if (x < -ONE_Q30) x = -ONE_Q30;
      if (y > ONE_Q30) y = ONE_Q30;
      if (y < -ONE_Q30) y = -ONE_Q30;
      case (ang[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint scale_round(longint unsigned a, longint b);
      longint unsigned m, p;
      m = (b < 0) ? -b : b;
      p = (a * m + 64'd536870912) >> 30;
      return (b < 0) ? -longint'(p) : longint'(p);
    endfunction

    function void note_request(logic [TIME_W-1:0] t_in);
      longint unsigned t, wm, w, f32, ad, e31, as_v;
      longint d31, dev, c, s, mc, ms;
      logic [127:0] p;
      logic [23:0] ph, term;
      logic odd;
      phasor_t r;
      t = t_in;
      ph = 24'((64'(base_f) * t) >> 16);
      ph = ph + {init_ph, 8'd0};
      wm = 64'(mod_f) * t;
      term = '0;
      if (zigzag) begin
        w = wm << 1;
        odd = w[40];
        f32 = w[39:8];
        d31 = longint'(f32) - 64'sd2147483648;
        ad = (d31 < 0) ? -d31 : d31;
        e31 = ((64'd1 << 62) - ad * ad) >> 31;
        p = 128'(64'(mod_a) * e31) * 128'(INV_PI_SQ_Q32);
        term = p[78:55];
        if (odd) term = -term;
        dev = longint'((64'(mod_a) * ad + 64'd1073741824) >> 31);
        if ((d31 < 0) != !odd) dev = -dev;
      end else begin
        rotate(wm[39:8], mc, ms);
        if (mod_f != 0) begin
          as_v = (ms < 0) ? -ms : ms;
          p = 128'((64'(mod_a) * as_v) / 64'(mod_f)) * 128'(INV_TWO_PI_Q32);
          term = p[61:38];
          if (ms < 0) term = -term;
        end
        dev = scale_round(mod_a, mc);
      end
      ph = ph + term;
      rotate({ph, 8'd0}, c, s);
      r.re = SIG_W'(scale_round(mag, c));
      r.im = SIG_W'(scale_round(mag, s));
      r.freq = IFREQ_W'(longint'(base_f) + dev);
      pending_q.push_back(r);
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endfunction

    function void check(phasor_t got);
      phasor_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result, real", got.re, 0);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.re !== want.re) report("signal_real", got.re, want.re);
      if (got.im !== want.im) report("signal_imag", got.im, want.im);
      if (got.freq !== want.freq) report("instant_frequency", got.freq, want.freq);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [TIME_W-1:0] in_sample_time;
  logic out_valid;
  logic out_stall;
  logic signed [SIG_W-1:0] out_signal_real;
  logic signed [SIG_W-1:0] out_signal_imag;
  logic signed [IFREQ_W-1:0] out_instant_frequency;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  phasor_scoreboard sb = new();
  int accepted = 0;
  bit long_hold = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  fm_cosine_phasor_generator_top dut (.*);

  always #5 clk = ~clk;

  initial begin
    rst_n <= 0;
    in_valid <= 0;
    in_sample_time <= '0;
    out_stall <= 0;
    cfg_valid <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
  end

  // receiver stall pattern: one of four styles, chosen anew at random
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (long_hold) out_stall <= 1;
    else case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= (stall_tick % 5 < 2);
      default: out_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check('{out_signal_real, out_signal_imag, out_instant_frequency});
  end

  // hold off the receiver long enough to back the pipeline up
  initial begin
    wait (accepted >= 400);
    @(posedge clk);
    long_hold = 1;
    repeat (400) @(posedge clk);
    long_hold = 0;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic send_request(logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_sample_time <= t;
    do @(posedge clk); while (in_stall);
    sb.note_request(t);
    accepted++;
  endtask

  task automatic drain();
    in_valid <= 0;
    wait (sb.pending_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic setup(logic [23:0] m, logic [15:0] ip, logic [31:0] bf,
                       logic [31:0] fm, logic [31:0] am, logic zz);
    write_reg(CFG_MAGNITUDE, {$urandom_range(0, 255), m});
    write_reg(CFG_INITIAL_PHASE, {16'($urandom), ip});
    write_reg(CFG_BASE_FREQ, bf);
    write_reg(CFG_MOD_FREQ, fm);
    write_reg(CFG_MOD_AMP, am);
    write_reg(CFG_ZIGZAG, {31'($urandom), zz});
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 65535));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 5))
      0: return TIME_W'($urandom_range(0, 4095));
      1: return {8'hFF, $urandom};
      default: return {8'($urandom), $urandom};
    endcase
  endfunction

  task automatic directed_times();
    send_request('0);
    send_request(40'd1);
    send_request({TIME_W{1'b1}});
    send_request(40'h80_0000_0000);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // all registers at reset: zero output, zero frequency
    directed_times();
    drain();
    write_reg(CFG_UNUSED_IDX, $urandom);
    write_reg(CFG_LAST_IDX, $urandom);
    // full scale, no modulation frequency
    setup(24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
    directed_times();
    drain();
    // large deviation with tiny modulation rate
    setup(24'hFF_FFFF, 16'h4000, 32'd65536, 32'd1, 32'hFFFF_FFFF, 1'b0);
    directed_times();
    drain();
    // zigzag at the extremes
    setup(24'hFF_FFFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    directed_times();
    drain();
    // zero magnitude with modulation still running
    setup(24'd0, 16'h1234, 32'h0001_0000, 32'h0002_0000, 32'h00FF_0000, 1'b1);
    directed_times();
    send_request({TIME_W{1'b1}} >> 1);
    drain();
    for (int ph = 0; ph < 10; ph++) begin
      setup(($urandom_range(0, 3) == 0) ? 24'hFF_FFFF : 24'($urandom),
            16'($urandom), pick32(), pick32(), pick32(), ph[0]);
      repeat (113) send_request(pick_time());
      drain();
    end
    $display("covered %0d requests over 15 register settings, %0d results checked",
             accepted, sb.checked);
    $display("both modulation modes, zero and full-scale registers, long output hold");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS fm_cosine_phasor_generator_top");
    end else begin
      $display("FAIL fm_cosine_phasor_generator_top");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", sb.pending_q.size());
    $display("FAIL fm_cosine_phasor_generator_top");
    $finish;
  end

endmodule
